// ===== rtl/core/csq_pkg.sv =====
// Shared types and constants for the counting semaphore with its wait queue.
// Used by every module under rtl/core; depends on nothing else.

package csq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 16;
    localparam int INIT_W          = 15;
    localparam int THREAD_W        = 8;
    localparam int TIMEOUT_W       = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

    typedef enum logic [1:0] {
        OP_WAIT   = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_TWAIT  = 2'd2,
        OP_CLOSE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_PROCEED      = 3'd0,
        ST_BLOCKED      = 3'd1,
        ST_WOKEN        = 3'd2,
        ST_NO_HANDLE    = 3'd3,
        ST_ZERO_TIMEOUT = 3'd4,
        ST_QUEUE_FULL   = 3'd5,
        ST_SATURATED    = 3'd6
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [THREAD_W-1:0]   thread;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

// ===== rtl/core/csq_ram.sv =====
// Wait queue storage: one write port and one read port with registered read data.
// Depends on csq_pkg for the thread number width.

module csq_ram #(
    parameter int DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [csq_pkg::THREAD_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [csq_pkg::THREAD_W-1:0]  o_rdata
);

    logic [csq_pkg::THREAD_W-1:0] r_mem [DEPTH];
    logic [csq_pkg::THREAD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/csq_out.sv =====
// Two-entry result buffer between the controller and the output channel.
// Depends on csq_pkg for the result struct.

module csq_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csq_pkg::t_push                i_push,
    output logic                          o_space,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [csq_pkg::THREAD_W-1:0]  o_affected_thread,
    output logic                          o_last
);

    csq_pkg::t_result r_slot [2];
    logic [1:0]       r_cnt;
    logic             r_wp;
    logic             r_rp;
    logic             pop;

    assign pop = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_push.valid) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push.valid} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wp] <= i_push.res;
        end
    end

    // Space is taken from the registered fill, so the input side never waits on i_stall.
    assign o_space           = (r_cnt != 2'd2);
    assign o_valid           = (r_cnt != 2'd0);
    assign o_status          = r_slot[r_rp].status;
    assign o_affected_thread = r_slot[r_rp].thread;
    assign o_last            = r_slot[r_rp].last;

endmodule

// ===== rtl/core/csq_ctrl.sv =====
// Semaphore controller: count, queue pointers, request decode and the close drain.
// Depends on csq_pkg; drives the csq_ram ports and pushes results into csq_out.

module csq_ctrl #(
    parameter int DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FW = $clog2(DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [csq_pkg::INIT_W-1:0]     i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [csq_pkg::THREAD_W-1:0]   i_thread_id,
    input  logic [csq_pkg::TIMEOUT_W-1:0]  i_timeout,
    input  logic                           i_handle_missing,
    input  logic                           i_space,
    output csq_pkg::t_push                 o_push,
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [csq_pkg::THREAD_W-1:0]   o_ram_wdata,
    output logic                           o_ram_re,
    output logic [AW-1:0]                  o_ram_raddr,
    input  logic [csq_pkg::THREAD_W-1:0]   i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAKE,
        S_CRD,
        S_CWR
    } t_state;

    t_state                               r_state, n_state;
    logic signed [csq_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [AW-1:0]                        r_head, n_head;
    logic [AW-1:0]                        r_tail, n_tail;
    logic [FW-1:0]                        r_fill, n_fill;
    logic [csq_pkg::INIT_W-1:0]           r_init;

    logic                                 accept;
    logic signed [csq_pkg::COUNT_W-1:0]   count_inc;
    logic signed [csq_pkg::COUNT_W-1:0]   count_dec;
    logic signed [csq_pkg::COUNT_W-1:0]   count_reload;
    logic                                 count_pos;
    logic                                 inc_nonpos;
    logic                                 queue_full;
    logic [AW-1:0]                        head_next;
    logic [AW-1:0]                        tail_next;

    assign o_stall      = !((r_state == S_IDLE) && i_space);
    assign accept       = i_valid && !o_stall;
    assign count_inc    = r_count + 16'sd1;
    assign count_dec    = r_count - 16'sd1;
    assign count_reload = {1'b0, r_init};
    assign count_pos    = !r_count[csq_pkg::COUNT_W-1] && (r_count != '0);
    assign inc_nonpos   = count_inc[csq_pkg::COUNT_W-1] || (count_inc == '0);
    assign queue_full   = (r_fill == FW'(DEPTH));
    assign head_next    = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_next    = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        o_push     = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = i_thread_id;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_push.valid      = 1'b1;
                    o_push.res.status = csq_pkg::ST_PROCEED;
                    o_push.res.thread = '0;
                    o_push.res.last   = 1'b1;
                    if (i_handle_missing) begin
                        o_push.res.status = csq_pkg::ST_NO_HANDLE;
                    end else begin
                        case (csq_pkg::t_opcode'(i_opcode))
                            csq_pkg::OP_WAIT, csq_pkg::OP_TWAIT: begin
                                if ((i_opcode == csq_pkg::OP_TWAIT) && (i_timeout == '0)) begin
                                    o_push.res.status = csq_pkg::ST_ZERO_TIMEOUT;
                                end else if (count_pos) begin
                                    n_count = count_dec;
                                end else if (queue_full) begin
                                    o_push.res.status = csq_pkg::ST_QUEUE_FULL;
                                end else begin
                                    n_count           = count_dec;
                                    o_ram_we          = 1'b1;
                                    n_tail            = tail_next;
                                    n_fill            = r_fill + FW'(1);
                                    o_push.res.status = csq_pkg::ST_BLOCKED;
                                    o_push.res.thread = i_thread_id;
                                end
                            end
                            csq_pkg::OP_SIGNAL: begin
                                if (r_count == csq_pkg::COUNT_MAX) begin
                                    o_push.res.status = csq_pkg::ST_SATURATED;
                                end else begin
                                    n_count = count_inc;
                                    // A waiter is released; its number arrives from the
                                    // queue memory in the next cycle.
                                    if (inc_nonpos && (r_fill != '0)) begin
                                        o_push.valid = 1'b0;
                                        o_ram_re     = 1'b1;
                                        n_head       = head_next;
                                        n_fill       = r_fill - FW'(1);
                                        n_state      = S_WAKE;
                                    end
                                end
                            end
                            csq_pkg::OP_CLOSE: begin
                                if (r_fill == '0) begin
                                    n_count = count_reload;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else begin
                                    o_push.valid = 1'b0;
                                    n_state      = S_CRD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_WAKE: begin
                o_push.valid      = 1'b1;
                o_push.res.status = csq_pkg::ST_WOKEN;
                o_push.res.thread = i_ram_rdata;
                o_push.res.last   = 1'b1;
                n_state           = S_IDLE;
            end
            S_CRD: begin
                // Only this drain pushes results, so space seen here still holds
                // when the read data comes back.
                if (i_space) begin
                    o_ram_re = 1'b1;
                    n_head   = head_next;
                    n_fill   = r_fill - FW'(1);
                    n_state  = S_CWR;
                end
            end
            S_CWR: begin
                o_push.valid      = 1'b1;
                o_push.res.status = csq_pkg::ST_WOKEN;
                o_push.res.thread = i_ram_rdata;
                o_push.res.last   = (r_fill == '0);
                if (r_fill == '0) begin
                    n_count = count_reload;
                    n_head  = '0;
                    n_tail  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_init  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            if (i_cfg_wr_en) begin
                r_init <= i_cfg_wr_data;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("queue fill exceeds depth");

    a_count_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && r_count[csq_pkg::COUNT_W-1]
            |-> (r_count + csq_pkg::COUNT_W'(r_fill)) == '0)
        else $error("negative count does not match the number of waiters");

    a_push_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_space)
        else $error("result pushed into a full output buffer");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRD) |-> (r_fill != '0))
        else $error("close drain reading an empty queue");

    a_wake_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAKE) || (r_state == S_CWR) |-> $past(o_ram_re))
        else $error("woken result without a queue read");

endmodule

// ===== rtl/core/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a first-in first-out wait queue of thread numbers.
// Top level; instantiates csq_ctrl, csq_ram and csq_out, and uses csq_pkg.
//
// Requests enter on i_valid/o_stall with opcode, thread number, timeout and a
// missing-handle flag; results leave on o_valid/i_stall with a status, the
// thread blocked or woken, and o_last on the final result of each request.
// initial_count is written through i_cfg_wr_en/i_cfg_wr_data; the user must do
// so only while idle; the block itself does not enforce it. It is loaded into
// the count at the end of every close. A request that needs no queue read is
// decoded in the cycle it is accepted; its result is visible in the next cycle
// and the next request can follow at once. A signal that wakes a waiter reads
// the queue memory, then pushes the woken thread from S_WAKE. A close with
// waiters reads each waiter from the queue memory and pushes its result in turn
// (S_CRD, then S_CWR); without waiters it is done in the cycle it is accepted.
// Reset (synchronous, active low) clears the count, initial_count and the
// queue pointers; the queue memory needs no clearing pass.
// Results go into a two-entry buffer, so a request is still taken while one
// result waits on a stalled receiver; with both entries full the block raises
// o_stall until the receiver takes a result.

module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [csq_pkg::INIT_W-1:0]     i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [csq_pkg::THREAD_W-1:0]   i_thread_id,
    input  logic [csq_pkg::TIMEOUT_W-1:0]  i_timeout,
    input  logic                           i_handle_missing,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_status,
    output logic [csq_pkg::THREAD_W-1:0]   o_affected_thread,
    output logic                           o_last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    csq_pkg::t_push                 push;
    logic                           space;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [csq_pkg::THREAD_W-1:0]   ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [csq_pkg::THREAD_W-1:0]   ram_rdata;

    csq_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_thread_id      (i_thread_id),
        .i_timeout        (i_timeout),
        .i_handle_missing (i_handle_missing),
        .i_space          (space),
        .o_push           (push),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata)
    );

    csq_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    csq_out u_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_space           (space),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_affected_thread (o_affected_thread),
        .o_last            (o_last)
    );

endmodule
